@@ hdl/b2r_pkg.sv @@
package b2r_pkg;

  localparam int ValueWidth  = 12;
  localparam int DigitWidth  = 4;
  localparam int NumDigits   = 4;
  localparam int SymbolWidth = 8;
  localparam int CountWidth  = $clog2(ValueWidth + 1);
  localparam int PosWidth    = $clog2(NumDigits);
  localparam int StepWidth   = 3;

  localparam logic [SymbolWidth-1:0] SymI = 8'h49;
  localparam logic [SymbolWidth-1:0] SymV = 8'h56;
  localparam logic [SymbolWidth-1:0] SymX = 8'h58;
  localparam logic [SymbolWidth-1:0] SymL = 8'h4C;
  localparam logic [SymbolWidth-1:0] SymC = 8'h43;
  localparam logic [SymbolWidth-1:0] SymD = 8'h44;
  localparam logic [SymbolWidth-1:0] SymM = 8'h4D;

  localparam logic [PosWidth-1:0] PosThousands = 2'd3;

  localparam logic [DigitWidth-1:0] DigitFour = 4'd4;
  localparam logic [DigitWidth-1:0] DigitFive = 4'd5;
  localparam logic [DigitWidth-1:0] DigitNine = 4'd9;

  // Unit, five and ten symbols per decimal position, units first
  localparam logic [NumDigits-1:0][SymbolWidth-1:0] UnitSym = {SymM, SymC, SymX, SymI};
  localparam logic [NumDigits-1:0][SymbolWidth-1:0] FiveSym = {SymM, SymD, SymL, SymV};
  localparam logic [NumDigits-1:0][SymbolWidth-1:0] TenSym  = {SymM, SymM, SymC, SymX};

  // BCD digits handed from the extractor to the symbol sequencer
  typedef struct packed {
    logic                                 valid;
    logic [NumDigits-1:0][DigitWidth-1:0] digits;
  } b2r_bcd_t;

  // Number of symbols one digit produces
  function automatic logic [StepWidth-1:0] b2r_sym_count(
    input logic [PosWidth-1:0]   pos,
    input logic [DigitWidth-1:0] dig
  );
    logic [StepWidth-1:0] n;
    if (pos == PosThousands) begin
      n = dig[StepWidth-1:0];
    end else if (dig == DigitFour || dig == DigitNine) begin
      n = 3'd2;
    end else if (dig >= DigitFive) begin
      n = StepWidth'(dig - DigitFour);
    end else begin
      n = dig[StepWidth-1:0];
    end
    return n;
  endfunction

  // Symbol at a given step within one digit
  function automatic logic [SymbolWidth-1:0] b2r_sym_at(
    input logic [PosWidth-1:0]   pos,
    input logic [DigitWidth-1:0] dig,
    input logic [StepWidth-1:0]  step
  );
    logic [SymbolWidth-1:0] s;
    s = UnitSym[pos];
    if (pos == PosThousands) begin
      s = SymM;
    end else if (dig == DigitFour) begin
      s = (step == '0) ? UnitSym[pos] : FiveSym[pos];
    end else if (dig == DigitNine) begin
      s = (step == '0) ? UnitSym[pos] : TenSym[pos];
    end else if (dig >= DigitFive) begin
      s = (step == '0) ? FiveSym[pos] : UnitSym[pos];
    end
    return s;
  endfunction

endpackage

@@ hdl/binary_to_roman_numeral.sv @@
// Channel  Direction  Handshake              Payload
// in       request    in_valid_i/in_stall_o  value_i[11:0]
// out      result     out_valid_o/out_stall_i symbol_o[7:0], last_o
//
// An accepted value goes through bit-serial BCD extraction (one shift of the
// double-dabble register per cycle), a handover to the symbol sequencer, and
// emission at one symbol per cycle while the output is not stalled, with a
// step for each zero digit.
// in_stall_o stays high until the symbol sequencer has passed the units digit.
// Reset is asynchronous, active low, and leaves the block idle and empty.
// A stalled output holds its symbol and pauses the symbol sequencer.
module binary_to_roman_numeral import b2r_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [ValueWidth-1:0]  value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SymbolWidth-1:0] symbol_o,
  output logic                   last_o
);

  logic     busy_q, busy_d;
  logic     accept;
  logic     finish;
  b2r_bcd_t bcd;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = busy_q;

  // Hold busy from request accept until the sequencer finishes
  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (finish) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  b2r_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .value_i (value_i),
    .bcd_o   (bcd)
  );

  b2r_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bcd_i       (bcd),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .symbol_o    (symbol_o),
    .last_o      (last_o),
    .finish_o    (finish)
  );

endmodule

@@ hdl/b2r_dabble.sv @@
module b2r_dabble import b2r_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ValueWidth-1:0] value_i,
  output b2r_bcd_t              bcd_o
);

  logic [ValueWidth-1:0]                bin_q, bin_d;
  logic [NumDigits-1:0][DigitWidth-1:0] bcd_q, bcd_d, adj;
  logic [NumDigits*DigitWidth-1:0]      adj_bits;
  logic [CountWidth-1:0]                cnt_q, cnt_d;
  logic                                 run_q, run_d;
  logic                                 done_q, done_d;

  // Add three to every digit of five or more, then shift in one binary bit
  always_comb begin
    adj = bcd_q;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i] >= DigitFive) begin
        adj[i] = bcd_q[i] + 4'd3;
      end
    end
    adj_bits = adj;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d = value_i;
      bcd_d = '0;
      cnt_d = CountWidth'(ValueWidth);
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {adj_bits[NumDigits*DigitWidth-2:0], bin_q[ValueWidth-1]};
      bin_d = {bin_q[ValueWidth-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CountWidth'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  // Shift registers for the binary and decimal words
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign bcd_o.valid  = done_q;
  assign bcd_o.digits = bcd_q;

endmodule

@@ hdl/b2r_emit.sv @@
module b2r_emit import b2r_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  b2r_bcd_t               bcd_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [SymbolWidth-1:0] symbol_o,
  output logic                   last_o,
  output logic                   finish_o
);

  logic [NumDigits-1:0][DigitWidth-1:0] dig_q, dig_d;
  logic [PosWidth-1:0]                  pos_q, pos_d;
  logic [StepWidth-1:0]                 step_q, step_d;
  logic                                 act_q, act_d;
  logic                                 ov_q, ov_d;
  logic [SymbolWidth-1:0]               sym_q, sym_d;
  logic                                 last_q, last_d;

  logic [DigitWidth-1:0] cur_dig;
  logic [StepWidth-1:0]  n_sym;
  logic                  has_sym, adv, emit, end_dig, final_step, lower_zero;

  // Decode the current digit
  assign cur_dig    = dig_q[pos_q];
  assign n_sym      = b2r_sym_count(pos_q, cur_dig);
  assign has_sym    = step_q < n_sym;
  assign final_step = (step_q + 3'd1) == n_sym;
  assign adv        = act_q && (!ov_q || !out_stall_i);
  assign emit       = adv && has_sym;
  assign end_dig    = !has_sym || final_step;
  assign finish_o   = adv && end_dig && (pos_q == '0);

  // Check that every lower digit is zero
  always_comb begin
    lower_zero = 1'b1;
    for (int j = 0; j < NumDigits; j++) begin
      if ((PosWidth'(j) < pos_q) && (dig_q[j] != '0)) begin
        lower_zero = 1'b0;
      end
    end
  end

  // Advance through the digits one symbol at a time
  always_comb begin
    dig_d  = dig_q;
    pos_d  = pos_q;
    step_d = step_q;
    act_d  = act_q;
    if (bcd_i.valid) begin
      dig_d  = bcd_i.digits;
      pos_d  = PosThousands;
      step_d = '0;
      act_d  = 1'b1;
    end else if (adv) begin
      if (end_dig) begin
        step_d = '0;
        if (pos_q == '0) begin
          act_d = 1'b0;
        end else begin
          pos_d = pos_q - 1'b1;
        end
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  // Load the output register, drop it once taken
  always_comb begin
    ov_d   = ov_q;
    sym_d  = sym_q;
    last_d = last_q;
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    if (emit) begin
      ov_d   = 1'b1;
      sym_d  = b2r_sym_at(pos_q, cur_dig, step_q);
      last_d = final_step && lower_zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      step_q <= '0;
      act_q  <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      step_q <= step_d;
      act_q  <= act_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    sym_q  <= sym_d;
    last_q <= last_d;
  end

  assign out_valid_o = ov_q;
  assign symbol_o    = sym_q;
  assign last_o      = last_q;

  // A new digit set never arrives while a numeral is still in progress
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcd_i.valid |-> !act_q)
    else $error("digits arrived while sequencer active");

  // The final symbol of a numeral leaves nothing more to emit
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && final_step && lower_zero && !bcd_i.valid) |=> !(act_q && has_sym))
    else $error("symbol pending after last");

  // No digit gives more than four symbols
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> (step_q <= 3'd3))
    else $error("symbol step out of range");

endmodule
